// ===== src/assert_macros.svh =====
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== src/tia_pkg.sv =====
// Shared types and constants for track id association.
// No dependencies.
`default_nettype none
package tia_pkg;
  localparam int HistDepth = 16;
  localparam int FrameMax  = 16;
  localparam int CoordBits = 14;
  localparam int HIDX_W    = $clog2(HistDepth);
  localparam int HCNT_W    = $clog2(HistDepth + 1);
  localparam int FIDX_W    = $clog2(FrameMax);
  localparam int FCNT_W    = $clog2(FrameMax + 1);
  localparam int D2_W      = 2 * CoordBits + 3;
  localparam int QDEPTH    = 2;

  localparam logic ACT_DETECT = 1'b0;
  localparam logic ACT_FRAME  = 1'b1;

  localparam logic [1:0] CFG_MATCH = 2'd0;
  localparam logic [1:0] CFG_GAP   = 2'd1;
  localparam logic [1:0] CFG_AGE   = 2'd2;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    logic        action;
    coord_t      x;
    coord_t      y;
    coord_t      z;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic [15:0] track_id;
    logic        is_new;
    logic [4:0]  hcount;
    logic        overflow;
  } res_t;

  function automatic logic [D2_W-1:0] sqd(input coord_t a, input coord_t b);
    logic [CoordBits:0] d;
    logic [CoordBits:0] m;
    logic [D2_W-1:0] u;
    d = {a[CoordBits-1], a} - {b[CoordBits-1], b};
    m = d[CoordBits] ? -d : d;
    u = D2_W'(m);
    return u * u;
  endfunction
endpackage
`default_nettype wire

// ===== src/tia_queue.sv =====
// Short item queue between front and back parts.
// Depends on tia_pkg.
`default_nettype none
module tia_queue import tia_pkg::*; (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   wr_en,
  input  wire   item_t wr_data,
  output logic  full,
  input  wire   rd_en,
  output item_t rd_data,
  output logic  empty
);
  item_t mem [QDEPTH];
  logic [$clog2(QDEPTH):0] wp_r, rp_r;
  localparam int PW = $clog2(QDEPTH);

  assign empty   = (wp_r == rp_r);
  assign full    = (wp_r[PW] != rp_r[PW]) && (wp_r[PW-1:0] == rp_r[PW-1:0]);
  assign rd_data = mem[rp_r[PW-1:0]];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r[PW-1:0]] <= wr_data;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== src/tia_engine.sv =====
// Back part: history search, frame store and frame-end update sequencer.
// Depends on tia_pkg.
`default_nettype none
module tia_engine import tia_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire  [12:0] match_mm,
  input  wire  [15:0] gap_ms,
  input  wire  [15:0] age_ms,
  input  wire         q_empty,
  input  wire  item_t q_data,
  output logic        q_pop,
  output logic        res_valid,
  output res_t        res,
  input  wire         res_take
);
  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_AGE, S_NEAR, S_APP, S_SHIFT, S_DONE, S_OUT
  } st_t;

  coord_t      hx [HistDepth];
  coord_t      hy [HistDepth];
  coord_t      hz [HistDepth];
  logic [31:0] ht [HistDepth];
  logic [15:0] hid [HistDepth];
  coord_t      fx [FrameMax];
  coord_t      fy [FrameMax];
  coord_t      fz [FrameMax];
  logic [15:0] fid [FrameMax];

  st_t st_r, ret_r;
  item_t it_r;
  logic [HCNT_W-1:0] hcnt_r;
  logic [FCNT_W-1:0] fcnt_r, lfc_r, f_r;
  logic [15:0] idc_r;
  logic [31:0] ldt_r;
  logic [HCNT_W-1:0] i_r, sh_r;
  logic [31:0] bt_r;
  logic [D2_W-1:0] bd_r, md2_r;
  logic found_r;
  logic [15:0] bid_r;
  logic dsel_f;
  res_t res_r;

  logic [HIDX_W-1:0] ii, ss;
  logic [FIDX_W-1:0] fi;
  coord_t px, py, pz;
  logic [D2_W-1:0] d2, mm_w, md2;
  logic [31:0] dt;
  logic aged;
  assign ii = i_r[HIDX_W-1:0];
  assign ss = sh_r[HIDX_W-1:0];
  assign fi = f_r[FIDX_W-1:0];
  assign px = dsel_f ? fx[fi] : it_r.x;
  assign py = dsel_f ? fy[fi] : it_r.y;
  assign pz = dsel_f ? fz[fi] : it_r.z;
  assign dsel_f = (st_r == S_NEAR);
  assign d2 = sqd(px, hx[ii]) + sqd(py, hy[ii]) + sqd(pz, hz[ii]);
  assign dt = it_r.now - ht[0];
  assign mm_w = D2_W'(match_mm);
  assign md2 = mm_w * mm_w;
  assign aged = (hcnt_r != '0) && (it_r.now > ht[0]) && (dt > {16'd0, age_ms});

  assign q_pop     = (st_r == S_IDLE) && !q_empty;
  assign res_valid = (st_r == S_OUT);
  assign res       = res_r;

  logic gap;
  logic [31:0] gd;
  assign gd  = q_data.now - ldt_r;
  assign gap = (ldt_r != 0) && (q_data.now > ldt_r) && (gd > {16'd0, gap_ms});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; hcnt_r <= '0; fcnt_r <= '0; lfc_r <= '0;
      idc_r <= '0; ldt_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: if (!q_empty) begin
          it_r <= q_data;
          md2_r <= md2;
          bd_r <= md2;
          bt_r <= '0; found_r <= 1'b0; f_r <= '0;
          if (q_data.action == ACT_FRAME) begin
            i_r <= '0; st_r <= S_AGE;
          end else begin
            // forced new id: start the scan at its end
            i_r <= (gap || lfc_r == 0) ? hcnt_r : '0;
            st_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (i_r < hcnt_r) begin
            if (ht[ii] > bt_r && d2 < bd_r) begin
              bt_r <= ht[ii]; bd_r <= d2; bid_r <= hid[ii]; found_r <= 1'b1;
            end
            i_r <= i_r + 1'b1;
          end else begin
            res_r.is_new <= !found_r;
            res_r.hcount <= 5'(hcnt_r);
            if (found_r) res_r.track_id <= bid_r;
            else begin
              res_r.track_id <= idc_r + 16'd1; idc_r <= idc_r + 16'd1;
            end
            res_r.overflow <= (fcnt_r >= FCNT_W'(FrameMax));
            if (fcnt_r < FCNT_W'(FrameMax)) begin
              fx[fcnt_r[FIDX_W-1:0]] <= it_r.x;
              fy[fcnt_r[FIDX_W-1:0]] <= it_r.y;
              fz[fcnt_r[FIDX_W-1:0]] <= it_r.z;
              fid[fcnt_r[FIDX_W-1:0]] <= found_r ? bid_r : idc_r + 16'd1;
              fcnt_r <= fcnt_r + 1'b1;
            end
            st_r <= S_OUT;
          end
        end
        S_AGE: begin
          if (aged) begin
            sh_r <= '0; ret_r <= S_AGE; st_r <= S_SHIFT;
          end else begin
            i_r <= '0; st_r <= (f_r < fcnt_r) ? S_NEAR : S_DONE;
          end
        end
        S_NEAR: begin
          if (i_r < hcnt_r) begin
            if (d2 < md2_r) begin
              sh_r <= i_r; ret_r <= S_NEAR; st_r <= S_SHIFT;
            end else i_r <= i_r + 1'b1;
          end else if (hcnt_r >= HCNT_W'(HistDepth)) begin
            sh_r <= '0; ret_r <= S_APP; st_r <= S_SHIFT;
          end else st_r <= S_APP;
        end
        S_SHIFT: begin
          // compact one entry per cycle, then return to caller
          if (sh_r + 1'b1 < hcnt_r) begin
            hx[ss] <= hx[ss+1'b1]; hy[ss] <= hy[ss+1'b1];
            hz[ss] <= hz[ss+1'b1]; ht[ss] <= ht[ss+1'b1];
            hid[ss] <= hid[ss+1'b1];
            sh_r <= sh_r + 1'b1;
          end else begin
            hcnt_r <= hcnt_r - 1'b1;
            st_r <= ret_r;
          end
        end
        S_APP: begin
          hx[hcnt_r[HIDX_W-1:0]] <= fx[fi]; hy[hcnt_r[HIDX_W-1:0]] <= fy[fi];
          hz[hcnt_r[HIDX_W-1:0]] <= fz[fi]; ht[hcnt_r[HIDX_W-1:0]] <= it_r.now;
          hid[hcnt_r[HIDX_W-1:0]] <= fid[fi];
          hcnt_r <= hcnt_r + 1'b1;
          f_r <= f_r + 1'b1; i_r <= '0;
          st_r <= (f_r + 1'b1 < fcnt_r) ? S_NEAR : S_DONE;
        end
        S_DONE: begin
          if (fcnt_r != 0) begin ldt_r <= it_r.now; lfc_r <= fcnt_r; end
          fcnt_r <= '0;
          res_r.track_id <= '0; res_r.is_new <= 1'b0; res_r.overflow <= 1'b0;
          res_r.hcount <= 5'(hcnt_r);
          st_r <= S_OUT;
        end
        S_OUT: if (res_take) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/tia_front.sv =====
// Front part: configuration registers and input acceptance into the queue.
// Depends on tia_pkg.
`default_nettype none
module tia_front import tia_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data,
  output logic [12:0] match_mm,
  output logic [15:0] gap_ms,
  output logic [15:0] age_ms,
  input  wire         in_push,
  output logic        in_full,
  input  wire  item_t in_item,
  output logic        q_wr,
  output item_t       q_data,
  input  wire         q_full
);
  logic [12:0] match_r;
  logic [15:0] gap_r, age_r;
  assign cfg_ready = 1'b1;
  assign match_mm = match_r;
  assign gap_ms = gap_r;
  assign age_ms = age_r;
  assign in_full = q_full;
  assign q_wr = in_push && !q_full;
  assign q_data = in_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 13'd1200; gap_r <= 16'd1200; age_r <= 16'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MATCH: match_r <= cfg_data[12:0];
        CFG_GAP:   gap_r <= cfg_data;
        CFG_AGE:   age_r <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/track_id_association_top.sv =====
// Track id association: detection ids from a 16-entry history buffer.
// Detection: the engine scans the history, then presents the result (a
// forced new id skips the scan), and takes no new word before a pop.
// Frame end: aged entries are dropped, then for each stored detection the
// near entries drop and it is appended (compaction moves one entry a cycle).
// Synchronous active-low reset clears counts, id counter, queue; presets cfg.
`default_nettype none
module track_id_association_top import tia_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          push,
  output logic         full,
  input  wire          in_action,
  input  wire  [13:0]  in_pos_x,
  input  wire  [13:0]  in_pos_y,
  input  wire  [13:0]  in_pos_z,
  input  wire  [31:0]  in_frame_time_ms,
  output logic         empty,
  input  wire          pop,
  output logic [15:0]  out_track_id,
  output logic         out_is_new_track,
  output logic [4:0]   out_history_count,
  output logic         out_frame_overflow,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [1:0]   cfg_index,
  input  wire  [15:0]  cfg_data
);
  logic [12:0] match_mm;
  logic [15:0] gap_ms, age_ms;
  logic q_wr, q_full, q_empty, q_pop, res_valid;
  item_t in_item, q_in, q_out;
  res_t res;

  assign in_item = '{action: in_action, x: in_pos_x, y: in_pos_y, z: in_pos_z,
                     now: in_frame_time_ms};

  tia_front u_front (.clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .match_mm, .gap_ms, .age_ms, .in_push(push), .in_full(full), .in_item,
    .q_wr, .q_data(q_in), .q_full);

  tia_queue u_q (.clk, .rst_n, .wr_en(q_wr), .wr_data(q_in), .full(q_full),
    .rd_en(q_pop), .rd_data(q_out), .empty(q_empty));

  tia_engine u_eng (.clk, .rst_n, .match_mm, .gap_ms, .age_ms,
    .q_empty, .q_data(q_out), .q_pop, .res_valid, .res, .res_take(pop));

  assign empty = !res_valid;
  assign out_track_id = res.track_id;
  assign out_is_new_track = res.is_new;
  assign out_history_count = res.hcount;
  assign out_frame_overflow = res.overflow;
endmodule
`default_nettype wire

// ===== src/tia_checker.sv =====
// Port-level checker for track_id_association_top, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module tia_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        empty,
  input wire        pop,
  input wire [15:0] out_track_id,
  input wire        out_is_new_track,
  input wire [4:0]  out_history_count
);
  `CHK_IMPL(a_cnt, clk, rst_n, !empty, out_history_count <= 5'd16)
  `CHK_IMPL(a_new_id, clk, rst_n, !empty && out_is_new_track, out_track_id != 16'd0)
  `CHK_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_track_id))
endmodule
bind track_id_association_top tia_checker u_chk (.clk, .rst_n, .empty, .pop,
  .out_track_id, .out_is_new_track, .out_history_count);
`default_nettype wire

// ===== test/tb_track_id_association_top.sv =====
// Self-checking testbench for track_id_association_top: a predictor of the
// id assignment and history buffer, a queue-fed driver and a result monitor.
// Depends on tia_pkg and track_id_association_top.
module tb_track_id_association_top;
  import tia_pkg::*;

  typedef struct {
    logic        action;
    logic [13:0] x;
    logic [13:0] y;
    logic [13:0] z;
    logic [31:0] now;
  } det_t;

  typedef struct {
    logic [15:0] track_id;
    logic        is_new;
    logic [4:0]  hcount;
    logic        overflow;
  } ids_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic in_action = 1'b0;
  logic [13:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [31:0] in_frame_time_ms = '0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = CFG_MATCH;
  logic [15:0] cfg_data = '0;
  wire full, empty, cfg_ready;
  wire [15:0] out_track_id;
  wire out_is_new_track, out_frame_overflow;
  wire [4:0] out_history_count;

  track_id_association_top dut (
    .clk, .rst_n, .push, .full, .in_action, .in_pos_x, .in_pos_y,
    .in_pos_z, .in_frame_time_ms, .empty, .pop, .out_track_id,
    .out_is_new_track, .out_history_count, .out_frame_overflow,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint unsigned match_mm = 1200, gap_ms = 1200, age_ms = 1000;
  int h_x[16], h_y[16], h_z[16];
  logic [31:0] h_t[16];
  logic [15:0] h_id[16];
  int h_cnt = 0;
  int f_x[16], f_y[16], f_z[16];
  logic [15:0] f_id[16];
  int f_cnt = 0;
  logic [15:0] next_id = 0;
  logic [31:0] last_det_t = 0;
  int last_f_cnt = 0;

  det_t pending[$];
  ids_t expected_ids[$];
  int send_idle = 14, recv_idle = 86;
  int mismatches = 0, results_seen = 0;
  longint cycles = 0;

  function automatic longint unsigned sq3(int ax, int ay, int az, int bx, int by, int bz);
    longint dx, dy, dz;
    dx = ax - bx;
    dy = ay - by;
    dz = az - bz;
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic bit older_than(logic [31:0] now, logic [31:0] t, longint unsigned lim);
    return now > t && longint'(now - t) > lim;
  endfunction

  function automatic void drop_entry(int i);
    for (int k = i; k + 1 < h_cnt; k++) begin
      h_x[k] = h_x[k+1]; h_y[k] = h_y[k+1]; h_z[k] = h_z[k+1];
      h_t[k] = h_t[k+1]; h_id[k] = h_id[k+1];
    end
    h_cnt--;
  endfunction

  function automatic ids_t assign_ids(det_t d);
    ids_t r;
    int x, y, z, i;
    longint unsigned md2, best_d2, d2;
    logic [31:0] best_t;
    bit found;
    md2 = match_mm * match_mm;
    r = '{16'd0, 1'b0, 5'd0, 1'b0};
    if (d.action == ACT_DETECT) begin
      x = $signed(d.x); y = $signed(d.y); z = $signed(d.z);
      found = 1'b0;
      if ((last_det_t != 0 && older_than(d.now, last_det_t, gap_ms)) || last_f_cnt == 0) begin
        found = 1'b0;
      end else begin
        best_t = 0;
        best_d2 = md2;
        for (i = 0; i < h_cnt; i++) begin
          d2 = sq3(x, y, z, h_x[i], h_y[i], h_z[i]);
          if (h_t[i] > best_t && d2 < best_d2) begin
            best_t = h_t[i]; best_d2 = d2; r.track_id = h_id[i]; found = 1'b1;
          end
        end
      end
      if (!found) begin
        next_id++;
        r.track_id = next_id;
        r.is_new = 1'b1;
      end
      if (f_cnt < 16) begin
        f_x[f_cnt] = x; f_y[f_cnt] = y; f_z[f_cnt] = z; f_id[f_cnt] = r.track_id;
        f_cnt++;
      end else begin
        r.overflow = 1'b1;
      end
    end else begin
      while (h_cnt > 0 && older_than(d.now, h_t[0], age_ms)) drop_entry(0);
      for (int f = 0; f < f_cnt; f++) begin
        i = 0;
        while (i < h_cnt) begin
          if (sq3(f_x[f], f_y[f], f_z[f], h_x[i], h_y[i], h_z[i]) < md2) drop_entry(i);
          else i++;
        end
        if (h_cnt >= 16) drop_entry(0);
        h_x[h_cnt] = f_x[f]; h_y[h_cnt] = f_y[f]; h_z[h_cnt] = f_z[f];
        h_t[h_cnt] = d.now; h_id[h_cnt] = f_id[f];
        h_cnt++;
      end
      if (f_cnt > 0) begin
        last_det_t = d.now;
        last_f_cnt = f_cnt;
      end
      f_cnt = 0;
    end
    r.hcount = h_cnt[4:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        ids_t p;
        p = assign_ids(pending.pop_front());
        expected_ids.insert(expected_ids.size(), p);
      end
      if ((!push || !full) && pending.size() > 0 &&
          $urandom_range(99) >= send_idle) begin
        push <= 1'b1;
        in_action <= pending[0].action;
        in_pos_x <= pending[0].x;
        in_pos_y <= pending[0].y;
        in_pos_z <= pending[0].z;
        in_frame_time_ms <= pending[0].now;
      end else if (!push || !full) begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (pop && !empty) begin
        ids_t e;
        results_seen++;
        if (expected_ids.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: id %0d", out_track_id);
        end else begin
          e = expected_ids.pop_front();
          if (out_track_id !== e.track_id || out_is_new_track !== e.is_new ||
              out_history_count !== e.hcount || out_frame_overflow !== e.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp id %0d new %0d hist %0d ovf %0d, got %0d %0d %0d %0d",
                       e.track_id, e.is_new, e.hcount, e.overflow, out_track_id,
                       out_is_new_track, out_history_count, out_frame_overflow);
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
    if (cycles > 2000000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_item(logic act, int x, int y, int z, logic [31:0] t);
    det_t d;
    d.action = act; d.x = x[13:0]; d.y = y[13:0]; d.z = z[13:0]; d.now = t;
    pending.insert(pending.size(), d);
  endtask

  task automatic drain();
    while (pending.size() > 0 || expected_ids.size() > 0 || push) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MATCH: match_mm = val[12:0];
      CFG_GAP:   gap_ms = val;
      default:   age_ms = val;
    endcase
  endtask

  // a burst of frames with tracks wandering slowly near their last spot, with stray detections and time jumps
  task automatic add_frames(int frames, logic [31:0] t0, int step, int spread);
    int nt, px[6], py[6], pz[6];
    logic [31:0] t;
    t = t0;
    nt = $urandom_range(1, 6);
    for (int k = 0; k < 6; k++) begin
      px[k] = $urandom_range(16383) - 8192;
      py[k] = $urandom_range(16383) - 8192;
      pz[k] = $urandom_range(16383) - 8192;
    end
    for (int f = 0; f < frames; f++) begin
      for (int k = 0; k < nt; k++) begin
        if ($urandom_range(9) != 0) begin
          px[k] = px[k] + $urandom_range(2 * spread) - spread;
          py[k] = py[k] + $urandom_range(2 * spread) - spread;
          pz[k] = pz[k] + $urandom_range(2 * spread) - spread;
          add_item(ACT_DETECT, px[k], py[k], pz[k], t);
        end
      end
      if ($urandom_range(9) == 0)
        add_item(ACT_DETECT, $urandom_range(16383), $urandom_range(16383),
                 $urandom_range(16383), $urandom);
      add_item(ACT_FRAME, 0, 0, 0, t);
      t = t + $urandom_range(step) + 1;
      if ($urandom_range(15) == 0) t = t + $urandom_range(5000);
      if ($urandom_range(30) == 0) t = t - $urandom_range(300);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first frame, field extremes, frame store overflow,
    // backwards time, gap and aging
    add_item(ACT_DETECT, 8191, -8192, 0, 32'd100);
    add_item(ACT_DETECT, -8192, 8191, -1, 32'd100);
    add_item(ACT_FRAME, 0, 0, 0, 32'd100);
    add_item(ACT_DETECT, 8190, -8192, 5, 32'd150);
    add_item(ACT_DETECT, 0, 0, 0, 32'd150);
    for (int i = 0; i < 15; i++) add_item(ACT_DETECT, i * 100, 0, 0, 32'd150);
    add_item(ACT_FRAME, 0, 0, 0, 32'd150);
    add_item(ACT_DETECT, 8191, -8192, 0, 32'd90);
    add_item(ACT_FRAME, 0, 0, 0, 32'hFFFF_FFFF);
    add_item(ACT_DETECT, 8191, 8191, 8191, 32'hFFFF_FFFF);
    add_item(ACT_FRAME, 0, 0, 0, 32'hFFFF_FFFF);
    drain();

    write_reg(CFG_MATCH, 16'd1);
    write_reg(CFG_GAP, 16'hFFFF);
    write_reg(CFG_AGE, 16'd1);
    add_frames(20, 32'h0001_0000, 40, 3);
    drain();

    write_reg(CFG_MATCH, 16'd8191);
    write_reg(CFG_GAP, 16'd1);
    write_reg(CFG_AGE, 16'hFFFF);
    add_frames(20, 32'hFFFF_F000, 3, 400);
    drain();

    send_idle = 86; recv_idle = 14;
    write_reg(CFG_MATCH, 16'd300);
    write_reg(CFG_GAP, 16'd200);
    write_reg(CFG_AGE, 16'd150);
    add_frames(40, 32'd5000, 60, 150);
    drain();

    send_idle = 0; recv_idle = 0;
    write_reg(CFG_MATCH, 16'd1200);
    write_reg(CFG_GAP, 16'd1200);
    write_reg(CFG_AGE, 16'd1000);
    add_frames(40, 32'h8000_0000, 40, 500);
    drain();

    $display("covered %0d result words over five register settings", results_seen);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end
endmodule
